>>> design/ttf_pkg.sv
// Package for the thermocouple temperature filter.
// Holds the item, result and job types, the fixed widths and the conversion constants.
// No dependencies.
package ttf_pkg;

  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned CFG_W       = 13;
  localparam int unsigned TEMP_W      = 16;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;

  localparam int unsigned BURST_LEN   = 10;
  localparam int unsigned BURST_CNT_W = 4;
  localparam int unsigned BURST_SUM_W = 16;
  localparam int unsigned MEAN_SHIFT  = 3;

  localparam int unsigned JOB_DEPTH   = 8;
  localparam int unsigned RES_DEPTH   = 2;

  localparam int unsigned TIP_WINDOW_DEF      = 16;
  localparam int unsigned JUNCTION_WINDOW_DEF = 4;
  localparam int unsigned ADC_FULL_SCALE_DEF  = 4096;

  localparam int unsigned SCALE_MV        = 3300;
  localparam int unsigned SCALED_W        = 24;
  localparam int unsigned JUNCTION_OFFSET = 750 - 250;
  localparam int unsigned JUNCTION_CLAMP  = 400;
  localparam int unsigned SP_REF          = 1000;
  localparam int unsigned SP_REF_TRIM     = 10;
  localparam int unsigned COMP_BASE       = 80;
  localparam int unsigned COMP_DIV        = 3000 / 150;
  localparam int unsigned TIP_GAIN        = 1000;
  localparam int unsigned CJ_GAIN         = 807;

  typedef enum logic {
    REG_CAL_TEMP  = 1'b0,
    REG_SET_POINT = 1'b1
  } reg_idx_e;

  typedef enum logic {
    JOB_QUERY = 1'b0,
    JOB_BURST = 1'b1
  } job_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_AVG,
    ST_SCALE,
    ST_JADC,
    ST_PROD,
    ST_NUM,
    ST_DIV,
    ST_OUT
  } back_state_e;

  typedef struct packed {
    logic                take_reading;
    logic [SAMPLE_W-1:0] tip_sample;
    logic [SAMPLE_W-1:0] junction_sample;
  } item_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temperature;
    logic              fresh;
  } result_t;

  typedef struct packed {
    job_kind_e           kind;
    logic [SAMPLE_W-1:0] tip_mean;
    logic [SAMPLE_W-1:0] cj_mean;
  } job_t;

endpackage

>>> design/ttf_fifo.sv
// Small synchronous queue in flip-flops, used for jobs and for results.
// Depends on nothing; the depth must be a power of two.
module ttf_fifo #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(DEPTH))
    else $error("Queue count exceeds its depth.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("Beat pushed into a full queue.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("Beat popped from an empty queue.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("Queue count did not follow a lone push.");

endmodule

>>> design/ttf_front.sv
// Front end: gathers sample pairs into bursts of ten and issues jobs.
// Depends on ttf_pkg.
module ttf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  ttf_pkg::item_t item_i,
  output ttf_pkg::job_t  job_o,
  output logic           job_push_o
);
  import ttf_pkg::*;

  logic [BURST_CNT_W-1:0] cnt_q, cnt_d;
  logic [BURST_SUM_W-1:0] tip_sum_q, tip_sum_d, cj_sum_q, cj_sum_d;
  logic [SAMPLE_W-1:0]    tip_max_q, tip_max_d, tip_min_q, tip_min_d;
  logic [SAMPLE_W-1:0]    cj_max_q, cj_max_d, cj_min_q, cj_min_d;
  logic [BURST_SUM_W-1:0] tip_trim, cj_trim;
  logic                   first, last, take;

  assign take  = accept_i & item_i.take_reading;
  assign first = (cnt_q == '0);
  assign last  = (cnt_q == BURST_CNT_W'(BURST_LEN - 1));

  always_comb begin
    tip_sum_d = first ? BURST_SUM_W'(item_i.tip_sample)
                      : tip_sum_q + BURST_SUM_W'(item_i.tip_sample);
    cj_sum_d  = first ? BURST_SUM_W'(item_i.junction_sample)
                      : cj_sum_q + BURST_SUM_W'(item_i.junction_sample);
    tip_max_d = (first || item_i.tip_sample > tip_max_q) ? item_i.tip_sample : tip_max_q;
    tip_min_d = (first || item_i.tip_sample < tip_min_q) ? item_i.tip_sample : tip_min_q;
    cj_max_d  = (first || item_i.junction_sample > cj_max_q) ? item_i.junction_sample
                                                            : cj_max_q;
    cj_min_d  = (first || item_i.junction_sample < cj_min_q) ? item_i.junction_sample
                                                            : cj_min_q;
    cnt_d     = last ? '0 : cnt_q + 1'b1;
    tip_trim  = tip_sum_d - BURST_SUM_W'(tip_max_d) - BURST_SUM_W'(tip_min_d);
    cj_trim   = cj_sum_d - BURST_SUM_W'(cj_max_d) - BURST_SUM_W'(cj_min_d);
  end

  always_comb begin
    job_o.kind     = item_i.take_reading ? JOB_BURST : JOB_QUERY;
    job_o.tip_mean = tip_trim[MEAN_SHIFT +: SAMPLE_W];
    job_o.cj_mean  = cj_trim[MEAN_SHIFT +: SAMPLE_W];
    job_push_o     = accept_i & (~item_i.take_reading | last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      tip_sum_q <= '0;
      tip_max_q <= '0;
      tip_min_q <= '0;
      cj_sum_q  <= '0;
      cj_max_q  <= '0;
      cj_min_q  <= '0;
    end else if (take) begin
      cnt_q     <= cnt_d;
      tip_sum_q <= tip_sum_d;
      tip_max_q <= tip_max_d;
      tip_min_q <= tip_min_d;
      cj_sum_q  <= cj_sum_d;
      cj_max_q  <= cj_max_d;
      cj_min_q  <= cj_min_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= BURST_CNT_W'(BURST_LEN - 1))
    else $error("Burst count ran past the burst length.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && last) |=> cnt_q == '0)
    else $error("Burst count did not restart after the tenth pair.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !item_i.take_reading) |=> $stable(cnt_q) && $stable(tip_sum_q))
    else $error("A query disturbed the burst in progress.");

endmodule

>>> design/ttf_back.sv
// Back end: moving averages, junction conversion, offset compensation and the final scaling.
// Depends on ttf_pkg; takes jobs from the job queue and pushes results to the result queue.
module ttf_back #(
  parameter int unsigned TIP_WINDOW      = ttf_pkg::TIP_WINDOW_DEF,
  parameter int unsigned JUNCTION_WINDOW = ttf_pkg::JUNCTION_WINDOW_DEF,
  parameter int unsigned ADC_FULL_SCALE  = ttf_pkg::ADC_FULL_SCALE_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ttf_pkg::job_t             job_i,
  input  logic                      job_valid_i,
  output logic                      job_pop_o,
  input  logic [ttf_pkg::CFG_W-1:0] cal_temp_i,
  input  logic [ttf_pkg::CFG_W-1:0] set_point_i,
  output ttf_pkg::result_t          res_o,
  output logic                      res_push_o,
  input  logic                      res_full_i
);
  import ttf_pkg::*;

  localparam int unsigned TIP_AW    = $clog2(TIP_WINDOW);
  localparam int unsigned TIP_SUM_W = SAMPLE_W + TIP_AW;
  localparam int unsigned TIP_K     = TIP_SUM_W + TIP_AW;
  localparam longint unsigned TIP_M =
    ((64'd1 << TIP_K) + TIP_WINDOW - 1) / TIP_WINDOW;
  localparam int unsigned TIP_PW    = 2 * TIP_SUM_W + 2;

  localparam int unsigned CJ_AW     = $clog2(JUNCTION_WINDOW);
  localparam int unsigned CJ_SUM_W  = SAMPLE_W + CJ_AW;
  localparam int unsigned CJ_K      = CJ_SUM_W + CJ_AW;
  localparam longint unsigned CJ_M  =
    ((64'd1 << CJ_K) + JUNCTION_WINDOW - 1) / JUNCTION_WINDOW;
  localparam int unsigned CJ_PW     = 2 * CJ_SUM_W + 2;

  localparam int unsigned ADC_AW    = $clog2(ADC_FULL_SCALE);
  localparam int unsigned ADC_K     = SCALED_W + ADC_AW;
  localparam longint unsigned ADC_M =
    ((64'd1 << ADC_K) + ADC_FULL_SCALE - 1) / ADC_FULL_SCALE;
  localparam int unsigned ADC_PW    = 2 * SCALED_W + 2;
  localparam int unsigned DEG_W     = SCALED_W + 1 - ADC_AW;
  localparam int unsigned DEG_X_W   = (DEG_W > 11) ? DEG_W + 1 : 12;
  localparam int unsigned CJV_W     = 11;

  localparam int unsigned COMP_AW   = $clog2(COMP_DIV);
  localparam int unsigned COMP_K    = CFG_W + COMP_AW;
  localparam longint unsigned COMP_M = ((64'd1 << COMP_K) + COMP_DIV - 1) / COMP_DIV;
  localparam int unsigned COMP_PW   = 2 * CFG_W + 2;
  localparam int unsigned COMP_Q_W  = CFG_W + 1 - COMP_AW;
  localparam int unsigned COMP_W    = COMP_Q_W + 2;
  localparam int unsigned LIM_W     = CFG_W + 2;
  localparam int unsigned DIFF_W    = CFG_W + 1;

  localparam int unsigned NUM_W     = 25;
  localparam int unsigned MAG_W     = NUM_W - 1;
  localparam int unsigned DIV_AW    = $clog2(CJ_GAIN);
  localparam int unsigned DIV_K     = MAG_W + DIV_AW;
  localparam longint unsigned DIV_M = ((64'd1 << DIV_K) + CJ_GAIN - 1) / CJ_GAIN;
  localparam int unsigned DIV_PW    = 2 * MAG_W + 2;
  localparam int unsigned Q_W       = MAG_W + 1 - DIV_AW;

  back_state_e state_q, state_d;
  logic        hist_we;

  logic [SAMPLE_W-1:0] tip_mem_q [TIP_WINDOW];
  logic [SAMPLE_W-1:0] cj_mem_q [JUNCTION_WINDOW];
  logic [TIP_WINDOW-1:0]      tip_vld_q;
  logic [JUNCTION_WINDOW-1:0] cj_vld_q;
  logic [TIP_AW-1:0]          tip_slot_q;
  logic [CJ_AW-1:0]           cj_slot_q;
  logic [SAMPLE_W-1:0]        tip_old_q, cj_old_q, tip_new_q, cj_new_q;
  logic                       tip_old_vld_q, cj_old_vld_q;
  logic [TIP_SUM_W-1:0]       tip_sum_q, tip_sum_d;
  logic [CJ_SUM_W-1:0]        cj_sum_q, cj_sum_d;
  logic [TEMP_W-1:0]          last_q, temp_out;

  logic [TIP_PW-1:0]   tip_prod;
  logic [CJ_PW-1:0]    cj_prod;
  logic [ADC_PW-1:0]   adc_prod;
  logic [COMP_PW-1:0]  comp_prod;
  logic [DIV_PW-1:0]   div_prod;
  logic [CFG_W-1:0]    sp_mag;
  logic [COMP_Q_W-1:0] cq_q;
  logic                sp_neg_q;
  logic signed [COMP_W-1:0] comp_q, comp_d;
  logic [SAMPLE_W-1:0] tip_avg_q, cj_avg_q, tip_adj_q;
  logic [SCALED_W-1:0] cj_scaled_q;
  logic [DEG_W-1:0]    cj_deg_q;
  logic signed [LIM_W-1:0]  tip_s, comp_s, cal_s, lim_s, adj_s;
  logic [DEG_X_W-1:0]       deg_x;
  logic signed [DEG_X_W-1:0] deg_off;
  logic signed [CJV_W-1:0]  cj_val;
  logic signed [DIFF_W-1:0] diff;
  logic signed [NUM_W-1:0]  p_tip_q, p_cj_q, num;
  logic                     neg_q;
  logic [MAG_W-1:0]         mag_q;
  logic [Q_W-1:0]           q_q;
  logic [TEMP_W-1:0]        q_ext;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i && job_i.kind == JOB_BURST) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM:   state_d = ST_AVG;
      ST_AVG:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_JADC;
      ST_JADC:  state_d = ST_PROD;
      ST_PROD:  state_d = ST_NUM;
      ST_NUM:   state_d = ST_DIV;
      ST_DIV:   state_d = ST_OUT;
      ST_OUT: begin
        if (!res_full_i) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o   = 1'b0;
    res_push_o  = 1'b0;
    hist_we     = 1'b0;
    res_o.temperature = last_q;
    res_o.fresh       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          if (job_i.kind == JOB_BURST) begin
            job_pop_o = 1'b1;
            hist_we   = 1'b1;
          end else if (!res_full_i) begin
            job_pop_o  = 1'b1;
            res_push_o = 1'b1;
          end
        end
      end
      ST_OUT: begin
        res_push_o        = ~res_full_i;
        res_o.temperature = temp_out;
        res_o.fresh       = 1'b1;
      end
      default: begin
        job_pop_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    tip_sum_d = tip_sum_q - (tip_old_vld_q ? TIP_SUM_W'(tip_old_q) : '0)
              + TIP_SUM_W'(tip_new_q);
    cj_sum_d  = cj_sum_q - (cj_old_vld_q ? CJ_SUM_W'(cj_old_q) : '0)
              + CJ_SUM_W'(cj_new_q);
    sp_mag    = (set_point_i >= CFG_W'(SP_REF)) ? set_point_i - CFG_W'(SP_REF)
                                                 : CFG_W'(SP_REF) - set_point_i;
    comp_prod = COMP_PW'(sp_mag) * COMP_PW'(COMP_M);
    tip_prod  = TIP_PW'(tip_sum_q) * TIP_PW'(TIP_M);
    cj_prod   = CJ_PW'(cj_sum_q) * CJ_PW'(CJ_M);
    adc_prod  = ADC_PW'(cj_scaled_q) * ADC_PW'(ADC_M);
    div_prod  = DIV_PW'(mag_q) * DIV_PW'(DIV_M);

    comp_d = sp_neg_q ? COMP_W'(COMP_BASE) - $signed(COMP_W'(cq_q))
                      : COMP_W'(COMP_BASE) + $signed(COMP_W'(cq_q));
    if (set_point_i == CFG_W'(SP_REF)) begin
      comp_d = comp_d - COMP_W'(SP_REF_TRIM);
    end

    tip_s  = $signed(LIM_W'(tip_avg_q));
    comp_s = LIM_W'(comp_q);
    cal_s  = $signed(LIM_W'(cal_temp_i));
    lim_s  = comp_s + cal_s;
    adj_s  = ((set_point_i != '0) && (tip_s > lim_s)) ? tip_s - comp_s : tip_s;

    deg_x   = DEG_X_W'(cj_deg_q);
    deg_off = $signed(deg_x) - $signed(DEG_X_W'(JUNCTION_OFFSET));
    cj_val  = (deg_x > DEG_X_W'(JUNCTION_CLAMP + JUNCTION_OFFSET))
            ? CJV_W'(JUNCTION_CLAMP) : deg_off[CJV_W-1:0];
    diff    = $signed(DIFF_W'(tip_adj_q)) - $signed(DIFF_W'(cal_temp_i));

    num   = p_tip_q + p_cj_q;
    q_ext = TEMP_W'(q_q);
    temp_out = neg_q ? TEMP_W'(0) - q_ext : q_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      tip_vld_q  <= '0;
      cj_vld_q   <= '0;
      tip_slot_q <= '0;
      cj_slot_q  <= '0;
      tip_sum_q  <= '0;
      cj_sum_q   <= '0;
      last_q     <= '0;
    end else begin
      state_q <= state_d;
      if (hist_we) begin
        tip_vld_q[tip_slot_q] <= 1'b1;
        cj_vld_q[cj_slot_q]   <= 1'b1;
        tip_slot_q <= (tip_slot_q == TIP_AW'(TIP_WINDOW - 1)) ? '0 : tip_slot_q + 1'b1;
        cj_slot_q  <= (cj_slot_q == CJ_AW'(JUNCTION_WINDOW - 1)) ? '0 : cj_slot_q + 1'b1;
      end
      if (state_q == ST_SUM) begin
        tip_sum_q <= tip_sum_d;
        cj_sum_q  <= cj_sum_d;
      end
      if (state_q == ST_OUT && !res_full_i) begin
        last_q <= temp_out;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      tip_mem_q[tip_slot_q] <= job_i.tip_mean;
      cj_mem_q[cj_slot_q]   <= job_i.cj_mean;
      tip_old_q     <= tip_mem_q[tip_slot_q];
      cj_old_q      <= cj_mem_q[cj_slot_q];
      tip_old_vld_q <= tip_vld_q[tip_slot_q];
      cj_old_vld_q  <= cj_vld_q[cj_slot_q];
      tip_new_q     <= job_i.tip_mean;
      cj_new_q      <= job_i.cj_mean;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SUM) begin
      cq_q     <= comp_prod[COMP_K +: COMP_Q_W];
      sp_neg_q <= (set_point_i < CFG_W'(SP_REF));
    end
    if (state_q == ST_AVG) begin
      tip_avg_q <= tip_prod[TIP_K +: SAMPLE_W];
      cj_avg_q  <= cj_prod[CJ_K +: SAMPLE_W];
      comp_q    <= comp_d;
    end
    if (state_q == ST_SCALE) begin
      cj_scaled_q <= SCALED_W'(cj_avg_q) * SCALED_W'(SCALE_MV);
      tip_adj_q   <= adj_s[SAMPLE_W-1:0];
    end
    if (state_q == ST_JADC) begin
      cj_deg_q <= adc_prod[ADC_K +: DEG_W];
    end
    if (state_q == ST_PROD) begin
      p_tip_q <= NUM_W'(diff) * $signed(NUM_W'(TIP_GAIN));
      p_cj_q  <= NUM_W'(cj_val) * $signed(NUM_W'(CJ_GAIN));
    end
    if (state_q == ST_NUM) begin
      neg_q <= num[NUM_W-1];
      mag_q <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
    end
    if (state_q == ST_DIV) begin
      q_q <= div_prod[DIV_K +: Q_W];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push_o |-> !res_full_i)
    else $error("Result beat pushed while the result queue is full.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> job_valid_i && state_q == ST_IDLE)
    else $error("Job taken outside the idle state.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) hist_we |=> state_q == ST_SUM)
    else $error("Burst job did not start the averaging sequence.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !res_full_i) |=> state_q == ST_IDLE && last_q == $past(temp_out))
    else $error("Fresh temperature was not kept as the last value.");

endmodule

>>> design/thermocouple_temperature_filter.sv
// Top level of the thermocouple temperature filter: configuration registers and queues.
// Depends on ttf_pkg, ttf_fifo, ttf_front and ttf_back.
//
// Input items enter through push/full and results leave through empty/pop; both sides behave
// as queues. A reading adds a tip and junction sample pair to the current burst of ten; only
// the tenth pair of a burst gives a result (fresh set). A query gives the last temperature
// with fresh clear, ordered behind any burst result still being worked out.
// The front end accepts one item per cycle unless full; its jobs go to an eight-entry queue.
// The back end answers a query from its idle state; a burst end passes through the states
// sum, avg, scale, jadc, prod, num, div and out for the
// averaging, junction conversion and scaling steps, and takes no new job until idle again.
// With up to seven queries between bursts the input is never held off.
// When the receiver stops popping, the two-entry result queue fills, the back end waits and
// then the job queue fills and full rises; nothing is lost.
// Reset clears the bursts, both averaging windows (through per-entry valid bits, so there is
// no clearing pass), the last temperature and both registers. The user must write, over APB,
// cal_temp 0x0, set_point 0x4 only while the block is idle (unchecked); pready is tied high.
module thermocouple_temperature_filter #(
  parameter int unsigned TIP_WINDOW      = ttf_pkg::TIP_WINDOW_DEF,
  parameter int unsigned JUNCTION_WINDOW = ttf_pkg::JUNCTION_WINDOW_DEF,
  parameter int unsigned ADC_FULL_SCALE  = ttf_pkg::ADC_FULL_SCALE_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  ttf_pkg::item_t             item_i,
  output logic                       empty,
  input  logic                       pop,
  output ttf_pkg::result_t           result_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ttf_pkg::ADDR_W-1:0] paddr,
  input  logic [ttf_pkg::DATA_W-1:0] pwdata,
  output logic [ttf_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import ttf_pkg::*;

  localparam int unsigned JOB_W = $bits(job_t);
  localparam int unsigned RES_W = $bits(result_t);

  logic [CFG_W-1:0] cal_q, sp_q;
  logic             cfg_we, accept;
  reg_idx_e         reg_idx;

  job_t             job_in, job_out;
  logic [JOB_W-1:0] job_vec;
  logic             job_push, job_full, job_empty, job_pop;
  result_t          res_in;
  logic [RES_W-1:0] res_vec;
  logic             res_push, res_full;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign accept  = push & ~full;
  assign full    = job_full;

  always_comb begin
    unique case (reg_idx)
      REG_CAL_TEMP:  prdata = DATA_W'(cal_q);
      REG_SET_POINT: prdata = DATA_W'(sp_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
      sp_q  <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_CAL_TEMP:  cal_q <= pwdata[CFG_W-1:0];
        REG_SET_POINT: sp_q  <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  ttf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .job_o      (job_in),
    .job_push_o (job_push)
  );

  ttf_fifo #(
    .DW    (JOB_W),
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_vec),
    .empty_o (job_empty)
  );

  assign job_out = job_t'(job_vec);

  ttf_back #(
    .TIP_WINDOW      (TIP_WINDOW),
    .JUNCTION_WINDOW (JUNCTION_WINDOW),
    .ADC_FULL_SCALE  (ADC_FULL_SCALE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_valid_i (~job_empty),
    .job_pop_o   (job_pop),
    .cal_temp_i  (cal_q),
    .set_point_i (sp_q),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  ttf_fifo #(
    .DW    (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop & ~empty),
    .data_o  (res_vec),
    .empty_o (empty)
  );

  assign result_o = result_t'(res_vec);

endmodule
